[hw/rtl/mite_pkg.sv]
`default_nettype none

package mite_pkg;

  localparam int XLEN       = 32;
  localparam int RF_DEPTH   = 32;
  localparam int RF_AW      = 5;
  // data memory depth in words, power of two
  localparam int DMEM_WORDS = 1024;
  localparam int DMEM_AW    = $clog2(DMEM_WORDS);

  localparam logic [XLEN-1:0] TRAP_RESET = 32'h8000_0180;
  localparam logic [RF_AW-1:0] LINK_REG  = 5'd31;

  // operation selector
  localparam logic [4:0] OP_ADDI   = 5'd0;
  localparam logic [4:0] OP_ADDIU  = 5'd1;
  localparam logic [4:0] OP_SLTI   = 5'd2;
  localparam logic [4:0] OP_SLTIU  = 5'd3;
  localparam logic [4:0] OP_ANDI   = 5'd4;
  localparam logic [4:0] OP_LUI    = 5'd5;
  localparam logic [4:0] OP_ORI    = 5'd6;
  localparam logic [4:0] OP_XORI   = 5'd7;
  localparam logic [4:0] OP_BEQ    = 5'd8;
  localparam logic [4:0] OP_BNE    = 5'd9;
  localparam logic [4:0] OP_BGEZ   = 5'd10;
  localparam logic [4:0] OP_BGTZ   = 5'd11;
  localparam logic [4:0] OP_BLEZ   = 5'd12;
  localparam logic [4:0] OP_BLTZ   = 5'd13;
  localparam logic [4:0] OP_BGEZAL = 5'd14;
  localparam logic [4:0] OP_BLTZAL = 5'd15;
  localparam logic [4:0] OP_LB     = 5'd16;
  localparam logic [4:0] OP_LBU    = 5'd17;
  localparam logic [4:0] OP_LH     = 5'd18;
  localparam logic [4:0] OP_LHU    = 5'd19;
  localparam logic [4:0] OP_LW     = 5'd20;
  localparam logic [4:0] OP_SB     = 5'd21;
  localparam logic [4:0] OP_SH     = 5'd22;
  localparam logic [4:0] OP_SW     = 5'd23;

  // exception cause
  localparam logic [1:0] CAUSE_OV   = 2'd0;
  localparam logic [1:0] CAUSE_ADEL = 2'd1;
  localparam logic [1:0] CAUSE_ADES = 2'd2;

  // memory access size
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  typedef struct packed {
    logic             en;
    logic [RF_AW-1:0] addr;
    logic [XLEN-1:0]  data;
  } rf_wr_t;

  typedef struct packed {
    logic               en;
    logic [DMEM_AW-1:0] idx;
    logic [XLEN-1:0]    data;
  } dm_wr_t;

endpackage

`default_nettype wire

[hw/rtl/mite_regfile.sv]
`default_nettype none

module mite_regfile (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     rd_en,
  input  wire logic [mite_pkg::RF_AW-1:0] rs_addr,
  input  wire logic [mite_pkg::RF_AW-1:0] rt_addr,
  output logic      [mite_pkg::XLEN-1:0]  rs_data,
  output logic      [mite_pkg::XLEN-1:0]  rt_data,
  input  wire mite_pkg::rf_wr_t         wr
);
  import mite_pkg::*;

  logic [XLEN-1:0]     mem [RF_DEPTH];
  logic [RF_DEPTH-1:0] vld;       // entry written since reset
  logic [XLEN-1:0]     rs_raw;
  logic [XLEN-1:0]     rt_raw;
  logic                rs_vld;
  logic                rt_vld;

  // read-before-write on a shared address; caller forwards
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rs_raw <= mem[rs_addr];
      rt_raw <= mem[rt_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rs_vld <= 1'b0;
      rt_vld <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rs_vld <= vld[rs_addr];
        rt_vld <= vld[rt_addr];
      end
    end
  end

  assign rs_data = rs_vld ? rs_raw : '0;
  assign rt_data = rt_vld ? rt_raw : '0;

endmodule

`default_nettype wire

[hw/rtl/mite_dmem.sv]
`default_nettype none

module mite_dmem (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       rd_en,
  input  wire logic [mite_pkg::DMEM_AW-1:0] rd_idx,
  output logic      [mite_pkg::XLEN-1:0]    rd_data,
  input  wire mite_pkg::dm_wr_t           wr,
  output logic                            busy
);
  import mite_pkg::*;

  logic [XLEN-1:0]    mem [DMEM_WORDS];
  logic [DMEM_AW-1:0] clr_idx;

  // zero sweep after reset, one word per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      clr_idx <= clr_idx + DMEM_AW'(1);
      if (clr_idx == DMEM_AW'(DMEM_WORDS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_idx] <= '0;
    end else if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mips_itype_execute_unit.sv]
`default_nettype none

// MIPS32 I-type execute unit. One decoded instruction per request on the
// input stream (opcode, instruction word, pc); one result per request on the
// output stream. A new request is taken every clock cycle unless the pipeline
// is backed up by a stalled output or the memory sweep runs. A result passes
// register read at the accepting edge, then execute/address, then memory/commit
// into the output register and waits there, up to two later requests behind it.
// The register file (two sync read ports) and the data memory (one
// sync read, one write port) are read-modify-written in order; register
// values are forwarded from the commit stage and from the last committed
// write, memory words from the last committed store. After reset the data
// memory is zeroed by a sweep over all DMEM_WORDS (1024) words during which no
// request is accepted; trap_address writes are accepted at any time but must
// only be issued while the unit is idle. Memory addresses wrap at the memory
// size. Exceptions (ADDI overflow, load/store misalignment) are taken only
// while the exception level flag is clear; a faulting instruction writes
// nothing either way.
module mips_itype_execute_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  // config write: trap_address
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [31:0]  cfg_data,
  // request: [4:0] opcode, [36:5] instruction_word, [68:37] instruction_address
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [71:0]  s_axis_tdata,
  // result: [31:0] next_pc, [32] pc_changed, [33] reg_write, [38:34] dest_reg,
  // [70:39] write_value, [71] exception_taken, [73:72] exception_code,
  // [105:74] fault_address, [137:106] return_address, [138] in_exception
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [143:0]      m_axis_tdata
);
  import mite_pkg::*;

  // ---------------- config ----------------
  logic [XLEN-1:0] trap_address;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trap_address <= TRAP_RESET;
    end else if (cfg_valid) begin
      trap_address <= cfg_data;
    end
  end

  // ---------------- pipeline control ----------------
  logic s1_valid, s2_valid, out_valid;
  logic out_adv, s2_free, s1_free, s1_move, s2_commit, in_fire;
  logic dm_busy;

  assign out_adv   = !out_valid || m_axis_tready;
  assign s2_free   = !s2_valid || out_adv;
  assign s1_free   = !s1_valid || s2_free;
  assign s1_move   = s1_valid && s2_free;
  assign s2_commit = s2_valid && out_adv;
  assign s_axis_tready = s1_free && !dm_busy;
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (s2_commit) begin
        s2_valid <= 1'b0;
      end
      if (s2_commit) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------- stage 0: register read ----------------
  logic [4:0]      in_op;
  logic [XLEN-1:0] in_iw;
  logic [XLEN-1:0] in_pc;
  rf_wr_t          rf_wr;
  logic [XLEN-1:0] rf_rs_data, rf_rt_data;

  assign in_op = s_axis_tdata[4:0];
  assign in_iw = s_axis_tdata[36:5];
  assign in_pc = s_axis_tdata[68:37];

  mite_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .rs_addr (in_iw[25:21]),
    .rt_addr (in_iw[20:16]),
    .rs_data (rf_rs_data),
    .rt_data (rf_rt_data),
    .wr      (rf_wr)
  );

  logic [4:0]      s1_op;
  logic [XLEN-1:0] s1_iw;
  logic [XLEN-1:0] s1_pc;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op <= in_op;
      s1_iw <= in_iw;
      s1_pc <= in_pc;
    end
  end

  // ---------------- stage 1: execute / address ----------------
  // last committed register write, covers the read that shared its edge
  logic             lw_en;
  logic [RF_AW-1:0] lw_dst;
  logic [XLEN-1:0]  lw_val;

  // commit-stage write (stage 2), driven below
  logic             s2_wr;
  logic [RF_AW-1:0] s2_dst;
  logic [XLEN-1:0]  s2_wval;

  logic [RF_AW-1:0] s1_rs, s1_rt;
  logic [XLEN-1:0]  a, b;
  logic [XLEN-1:0]  zimm, simm, addr, target, sum, link;
  logic             ovf;

  assign s1_rs = s1_iw[25:21];
  assign s1_rt = s1_iw[20:16];

  always_comb begin
    a = rf_rs_data;
    if (lw_en && lw_dst == s1_rs) a = lw_val;
    if (s2_valid && s2_wr && s2_dst == s1_rs) a = s2_wval;
    b = rf_rt_data;
    if (lw_en && lw_dst == s1_rt) b = lw_val;
    if (s2_valid && s2_wr && s2_dst == s1_rt) b = s2_wval;
  end

  assign zimm   = {16'h0000, s1_iw[15:0]};
  assign simm   = {{16{s1_iw[15]}}, s1_iw[15:0]};
  assign sum    = a + simm;
  assign addr   = sum;
  assign target = s1_pc + {simm[29:0], 2'b00};
  assign link   = s1_pc + 32'd8;
  assign ovf    = ((a[31] ^ sum[31]) & (simm[31] ^ sum[31]));

  logic             x_wants, x_fault, x_taken, x_load, x_store, x_lsign, x_setbad;
  logic [1:0]       x_size, x_cause;
  logic [RF_AW-1:0] x_dst;
  logic [XLEN-1:0]  x_val;

  always_comb begin
    x_wants  = 1'b0;
    x_fault  = 1'b0;
    x_taken  = 1'b0;
    x_load   = 1'b0;
    x_store  = 1'b0;
    x_lsign  = 1'b0;
    x_setbad = 1'b1;
    x_size   = SZ_WORD;
    x_cause  = CAUSE_OV;
    x_dst    = s1_rt;
    x_val    = '0;
    unique case (s1_op)
      OP_ADDI: begin
        x_val    = sum;
        x_wants  = 1'b1;
        x_fault  = ovf;
        x_setbad = 1'b0;
      end
      OP_ADDIU: begin x_val = sum; x_wants = 1'b1; end
      OP_SLTI: begin
        x_val   = {31'd0, $signed(a) < $signed(simm)};
        x_wants = 1'b1;
      end
      OP_SLTIU: begin x_val = {31'd0, a < simm}; x_wants = 1'b1; end
      OP_ANDI:  begin x_val = a & zimm; x_wants = 1'b1; end
      OP_LUI:   begin x_val = {s1_iw[15:0], 16'h0000}; x_wants = 1'b1; end
      OP_ORI:   begin x_val = a | zimm; x_wants = 1'b1; end
      OP_XORI:  begin x_val = a ^ zimm; x_wants = 1'b1; end
      OP_BEQ:   x_taken = (a == b);
      OP_BNE:   x_taken = (a != b);
      OP_BGEZ:  x_taken = !a[31];
      OP_BGTZ:  x_taken = !a[31] && (a != '0);
      OP_BLEZ:  x_taken = a[31] || (a == '0);
      OP_BLTZ:  x_taken = a[31];
      OP_BGEZAL, OP_BLTZAL: begin
        x_taken = (s1_op == OP_BGEZAL) ? !a[31] : a[31];
        x_dst   = LINK_REG;
        x_val   = link;
        x_wants = 1'b1;
      end
      OP_LB, OP_LBU: begin
        x_load  = 1'b1;
        x_lsign = (s1_op == OP_LB);
        x_size  = SZ_BYTE;
        x_wants = 1'b1;
      end
      OP_LH, OP_LHU: begin
        x_load  = 1'b1;
        x_lsign = (s1_op == OP_LH);
        x_size  = SZ_HALF;
        x_wants = 1'b1;
        x_fault = addr[0];
        x_cause = CAUSE_ADEL;
      end
      OP_LW: begin
        x_load  = 1'b1;
        x_wants = 1'b1;
        x_fault = addr[1] | addr[0];
        x_cause = CAUSE_ADEL;
      end
      OP_SB: begin x_store = 1'b1; x_size = SZ_BYTE; end
      OP_SH: begin
        x_store = 1'b1;
        x_size  = SZ_HALF;
        x_fault = addr[0];
        x_cause = CAUSE_ADES;
      end
      OP_SW: begin
        x_store = 1'b1;
        x_fault = addr[1] | addr[0];
        x_cause = CAUSE_ADES;
      end
      default: ;
    endcase
  end

  // data memory read for loads and store merges
  logic [XLEN-1:0] dm_rdata;
  dm_wr_t          dm_wr;

  mite_dmem u_dmem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (s1_move),
    .rd_idx  (addr[DMEM_AW+1:2]),
    .rd_data (dm_rdata),
    .wr      (dm_wr),
    .busy    (dm_busy)
  );

  logic [RF_AW-1:0]   s2_dst_r;
  logic [XLEN-1:0]    s2_val, s2_addr, s2_target, s2_pc, s2_b;
  logic               s2_wr_r, s2_fault, s2_taken, s2_load, s2_store, s2_lsign, s2_setbad;
  logic [1:0]         s2_size, s2_cause;

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_wr_r   <= x_wants && !x_fault && (x_dst != '0);
      s2_dst_r  <= x_dst;
      s2_val    <= x_val;
      s2_fault  <= x_fault;
      s2_cause  <= x_cause;
      s2_setbad <= x_setbad;
      s2_taken  <= x_taken;
      s2_load   <= x_load;
      s2_store  <= x_store && !x_fault;
      s2_lsign  <= x_lsign;
      s2_size   <= x_size;
      s2_addr   <= addr;
      s2_target <= target;
      s2_pc     <= s1_pc;
      s2_b      <= b;
    end
  end

  // ---------------- stage 2: memory / commit ----------------
  // last committed store, covers the read that shared its edge
  logic               ls_en;
  logic [DMEM_AW-1:0] ls_idx;
  logic [XLEN-1:0]    ls_word;

  logic [DMEM_AW-1:0] s2_idx;
  logic [XLEN-1:0]    word, shifted, ld_val, st_mask, st_data, st_word;
  logic [4:0]         bsh, hsh;

  assign s2_idx  = s2_addr[DMEM_AW+1:2];
  assign word    = (ls_en && ls_idx == s2_idx) ? ls_word : dm_rdata;
  assign bsh     = {s2_addr[1:0], 3'b000};
  assign hsh     = {s2_addr[1], 4'b0000};

  always_comb begin
    shifted = word;
    ld_val  = word;
    st_mask = '1;
    st_data = s2_b;
    unique case (s2_size)
      SZ_BYTE: begin
        shifted = word >> bsh;
        ld_val  = {{24{s2_lsign & shifted[7]}}, shifted[7:0]};
        st_mask = 32'h0000_00FF << bsh;
        st_data = s2_b << bsh;
      end
      SZ_HALF: begin
        shifted = word >> hsh;
        ld_val  = {{16{s2_lsign & shifted[15]}}, shifted[15:0]};
        st_mask = 32'h0000_FFFF << hsh;
        st_data = s2_b << hsh;
      end
      default: ;
    endcase
  end

  assign st_word = (word & ~st_mask) | (st_data & st_mask);
  assign s2_wr   = s2_wr_r;
  assign s2_dst  = s2_dst_r;
  assign s2_wval = s2_load ? ld_val : s2_val;

  assign rf_wr.en   = s2_commit && s2_wr;
  assign rf_wr.addr = s2_dst;
  assign rf_wr.data = s2_wval;

  assign dm_wr.en   = s2_commit && s2_store;
  assign dm_wr.idx  = s2_idx;
  assign dm_wr.data = st_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_en <= 1'b0;
      ls_en <= 1'b0;
    end else begin
      if (rf_wr.en) lw_en <= 1'b1;
      if (dm_wr.en) ls_en <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_wr.en) begin
      lw_dst <= s2_dst;
      lw_val <= s2_wval;
    end
    if (dm_wr.en) begin
      ls_idx  <= s2_idx;
      ls_word <= st_word;
    end
  end

  // exception state
  logic            exc_level, exc_level_next;
  logic [XLEN-1:0] epc, epc_next, bad_addr, bad_addr_next;
  logic [1:0]      cause, cause_next;
  logic            exc;
  logic [XLEN-1:0] npc;

  assign exc = s2_fault && !exc_level;

  always_comb begin
    exc_level_next = exc_level;
    epc_next       = epc;
    bad_addr_next  = bad_addr;
    cause_next     = cause;
    if (exc) begin
      exc_level_next = 1'b1;
      epc_next       = s2_pc;
      cause_next     = s2_cause;
      if (s2_setbad) bad_addr_next = s2_addr;
    end
  end

  assign npc = exc ? trap_address : (s2_taken ? s2_target : s2_pc);

  always_ff @(posedge clk) begin
    if (rst) begin
      exc_level <= 1'b0;
      epc       <= '0;
      bad_addr  <= '0;
      cause     <= CAUSE_OV;
    end else if (s2_commit) begin
      exc_level <= exc_level_next;
      epc       <= epc_next;
      bad_addr  <= bad_addr_next;
      cause     <= cause_next;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (s2_commit) begin
      m_axis_tdata[31:0]    <= npc;
      m_axis_tdata[32]      <= exc || s2_taken;
      m_axis_tdata[33]      <= s2_wr;
      m_axis_tdata[38:34]   <= s2_wr ? s2_dst : '0;
      m_axis_tdata[70:39]   <= s2_wr ? s2_wval : '0;
      m_axis_tdata[71]      <= exc;
      m_axis_tdata[73:72]   <= cause_next;
      m_axis_tdata[105:74]  <= bad_addr_next;
      m_axis_tdata[137:106] <= epc_next;
      m_axis_tdata[138]     <= exc_level_next;
      m_axis_tdata[143:139] <= '0;
    end
  end

  assign m_axis_tvalid = out_valid;

endmodule

`default_nettype wire
